/* rtl/core/igs_pkg.sv */
// shared types and constants for the gradient sharpness score block
`timescale 1ns / 1ps

package igs_pkg;

   localparam int PIX_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int SCORE_W    = 19;
   localparam int GRAD_W     = 15;

   // largest |7*diag + 10*direct| over one window
   localparam longint unsigned GRAD_MAX = 64'd17340;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_THRESHOLD = 2'd2;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RST    = 12'd2048;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RST   = 12'd2048;
   localparam logic [PIX_W-1:0]      ZERO_THRESHOLD_RST = 8'd190;

   typedef logic [PIX_W-1:0] pixel_type;

   // [row][col], row 0 is the oldest line, col 2 the newest column
   typedef pixel_type [2:0][2:0] window_type;

   typedef struct packed {
      logic valid;
      logic interior;
      logic last;
   } tag_type;

endpackage

/* rtl/core/igs_line_window.sv */
// two-line row store with read-modify-write and the 3x3 window registers
`timescale 1ns / 1ps

module igs_line_window
   import igs_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tag_type                      in_tag,
   input  pixel_type                    in_pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0] in_addr,
   output tag_type                      win_tag,
   output window_type                   window
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);

   // each word holds {line before previous, previous line} for one column
   logic [2*PIX_W-1:0] row_mem [MAX_WIDTH];

   logic [2*PIX_W-1:0] rd_data_ff;
   tag_type            s1_tag_ff;
   pixel_type          s1_pixel_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   tag_type            s2_tag_ff;
   window_type         window_ff;

   always_ff @(posedge clock) begin
      if (in_tag.valid) begin
         rd_data_ff  <= row_mem[in_addr];
         s1_pixel_ff <= in_pixel;
         s1_addr_ff  <= in_addr;
      end
      if (s1_tag_ff.valid) begin
         row_mem[s1_addr_ff] <= {rd_data_ff[PIX_W-1:0], s1_pixel_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         window_ff <= '0;
      end else begin
         s1_tag_ff <= in_tag;
         s2_tag_ff <= s1_tag_ff;
         if (s1_tag_ff.valid) begin
            for (int k = 0; k < 3; k++) begin
               window_ff[k][0] <= window_ff[k][1];
               window_ff[k][1] <= window_ff[k][2];
            end
            window_ff[0][2] <= rd_data_ff[2*PIX_W-1:PIX_W];
            window_ff[1][2] <= rd_data_ff[PIX_W-1:0];
            window_ff[2][2] <= s1_pixel_ff;
         end
      end
   end

   assign win_tag = s2_tag_ff;
   assign window  = window_ff;

endmodule

/* rtl/core/igs_grad_acc.sv */
// weighted window gradient and the per-frame accumulator
`timescale 1ns / 1ps

module igs_grad_acc
   import igs_pkg::*;
#(
   parameter int SUM_W = 37
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  tag_type          win_tag,
   input  window_type       window,
   output logic             frame_done,
   output logic [SUM_W-1:0] frame_sum
);

   logic signed [10:0] diag;
   logic signed [10:0] direct;
   logic signed [15:0] diag_x;
   logic signed [15:0] direct_x;
   logic signed [15:0] mix;
   logic [GRAD_W-1:0]  grad_in;

   logic [GRAD_W-1:0]  grad_ff;
   tag_type            s3_tag_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sum_in;

   always_comb begin
      diag = $signed({3'b000, window[0][0]}) + $signed({3'b000, window[0][2]})
           + $signed({3'b000, window[2][0]}) + $signed({3'b000, window[2][2]})
           - $signed({1'b0, window[1][1], 2'b00});
      direct = $signed({3'b000, window[0][1]}) + $signed({3'b000, window[1][0]})
             + $signed({3'b000, window[1][2]}) + $signed({3'b000, window[2][1]})
             - $signed({1'b0, window[1][1], 2'b00});
      diag_x   = 16'(diag);
      direct_x = 16'(direct);
      // 7*diag + 10*direct as shift-adds
      mix = (diag_x <<< 3) - diag_x + (direct_x <<< 3) + (direct_x <<< 1);
      grad_in = mix[15] ? GRAD_W'(-mix) : GRAD_W'(mix);
   end

   always_comb begin
      sum_in = sum_ff;
      if (s3_tag_ff.valid && s3_tag_ff.interior) begin
         sum_in = sum_ff + SUM_W'(grad_ff);
      end
   end

   always_ff @(posedge clock) begin
      grad_ff <= grad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_tag_ff <= '0;
         sum_ff    <= '0;
      end else begin
         s3_tag_ff <= win_tag;
         if (clear || (s3_tag_ff.valid && s3_tag_ff.last)) begin
            sum_ff <= '0;
         end else if (s3_tag_ff.valid) begin
            sum_ff <= sum_in;
         end
      end
   end

   assign frame_done = s3_tag_ff.valid && s3_tag_ff.last;
   assign frame_sum  = sum_in;

endmodule

/* rtl/core/igs_divider.sv */
// restoring divider, one quotient bit per cycle, saturating quotient
`timescale 1ns / 1ps

module igs_divider
   import igs_pkg::*;
#(
   parameter int SUM_W     = 37,
   parameter int DEN_W     = 26,
   parameter int FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   input  logic [DEN_W-1:0]   divisor,
   output logic               done,
   output logic [SCORE_W-1:0] quotient
);

   localparam int NUM_W = SUM_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic               busy_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [SCORE_W-1:0] q_ff;
   logic               ovf_ff;
   logic               done_ff;

   logic [DEN_W:0]     rem_sh;
   logic               ge;
   logic [DEN_W-1:0]   rem_in;

   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      ge     = rem_sh >= (DEN_W+1)'(den_ff);
      rem_in = ge ? DEN_W'(rem_sh - (DEN_W+1)'(den_ff)) : DEN_W'(rem_sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= NUM_W'(dividend) << FRAC_BITS;
         den_ff <= divisor;
         rem_ff <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_in;
         q_ff   <= {q_ff[SCORE_W-2:0], ge};
         ovf_ff <= ovf_ff | q_ff[SCORE_W-1];
      end
   end

   assign done     = done_ff;
   assign quotient = ovf_ff ? '1 : q_ff;

endmodule

/* rtl/core/image_gradient_sharpness_score.sv */
// top level: gradient sharpness score over a streamed grayscale frame
// throughput: one pixel per cycle inside a frame, set by the row store rmw (one read, one write)
// score path: row store read, window and gradient registers, then the bit-serial divider;
//   pixels of the next frame wait until the score transfers
// reset: synchronous active-high; registers go to 2048 / 2048 / 190, counters and sum clear
// the row store is not cleared; entries are always written before they feed a used window
`timescale 1ns / 1ps

module image_gradient_sharpness_score
   import igs_pkg::*;
#(
   parameter int MAX_WIDTH       = 2048,
   parameter int MAX_HEIGHT      = 2048,
   parameter int SCORE_FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel,
   // score output channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SCORE_W-1:0]    rsp_clarity_score,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // derived widths
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int H_W    = $clog2(MAX_HEIGHT + 1);
   localparam longint unsigned PIX_MAX =
      longint'(MAX_WIDTH - 2) * longint'(MAX_HEIGHT - 2);
   localparam int PROD_W = $clog2(PIX_MAX + 1);
   localparam int DEN_W  = $clog2(10 * PIX_MAX + 1);
   localparam int SUM_W  = $clog2(GRAD_MAX * PIX_MAX + 1);

   // configuration registers
   logic [CSR_DATA_W-1:0] frame_width_ff;
   logic [CSR_DATA_W-1:0] frame_height_ff;
   logic [PIX_W-1:0]      zero_threshold_ff;
   logic                  cfg_write;
   logic                  cfg_hit;

   // effective geometry after clamping to 3..MAX
   logic [W_W-1:0]        w_eff;
   logic [H_W-1:0]        h_eff;

   // raster position of the next pixel
   logic [COL_W-1:0]      col_ff;
   logic [ROW_W-1:0]      row_ff;
   logic                  last_col;
   logic                  last_row;

   // frame end handshake state
   logic                  frame_busy_ff;
   logic                  rsp_valid_ff;
   logic [SCORE_W-1:0]    rsp_score_ff;

   // divisor: 10 * interior pixel count, two registered steps
   logic [PROD_W-1:0]     prod_ff;
   logic [DEN_W-1:0]      den_ff;

   logic                  req_xfer;
   logic                  rsp_xfer;
   tag_type               in_tag;
   pixel_type             pixel_thr;
   tag_type               win_tag;
   window_type            window;
   logic                  frame_done;
   logic [SUM_W-1:0]      frame_sum;
   logic                  div_done;
   logic [SCORE_W-1:0]    div_quotient;

   // pixel intake stalls from the last pixel of a frame until its score transfers
   assign req_stall = frame_busy_ff;
   assign csr_ready = ~frame_busy_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign cfg_write = csr_valid && csr_ready;

   always_comb begin
      if (frame_width_ff < CSR_DATA_W'(3)) begin
         w_eff = W_W'(3);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = W_W'(MAX_WIDTH);
      end else begin
         w_eff = W_W'(frame_width_ff);
      end
      if (frame_height_ff < CSR_DATA_W'(3)) begin
         h_eff = H_W'(3);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         h_eff = H_W'(MAX_HEIGHT);
      end else begin
         h_eff = H_W'(frame_height_ff);
      end
   end

   assign last_col = (W_W'(col_ff) + W_W'(1)) == w_eff;
   assign last_row = (H_W'(row_ff) + H_W'(1)) == h_eff;

   // zero every pixel not strictly above the threshold
   assign pixel_thr = (req_pixel > zero_threshold_ff) ? req_pixel : '0;

   always_comb begin
      in_tag.valid    = req_xfer;
      in_tag.interior = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
      in_tag.last     = last_col && last_row;
   end

   // register writes, any known index restarts the frame
   always_comb begin
      cfg_hit = 1'b0;
      unique case (csr_index)
         REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_ZERO_THRESHOLD: cfg_hit = cfg_write;
         default: cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= FRAME_WIDTH_RST;
         frame_height_ff   <= FRAME_HEIGHT_RST;
         zero_threshold_ff <= ZERO_THRESHOLD_RST;
      end else if (cfg_write) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:    frame_width_ff    <= csr_wdata;
            REG_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata;
            REG_ZERO_THRESHOLD: zero_threshold_ff <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // raster counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cfg_hit) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_xfer) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // geometry is stable long before a frame ends, so the divisor just tracks it
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(PROD_W'(w_eff - W_W'(2)) * PROD_W'(h_eff - H_W'(2)));
      den_ff  <= (DEN_W'(prod_ff) << 3) + (DEN_W'(prod_ff) << 1);
   end

   // frame end and score output register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_busy_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_xfer && in_tag.last) begin
            frame_busy_ff <= 1'b1;
         end else if (rsp_xfer) begin
            frame_busy_ff <= 1'b0;
         end
         if (div_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         rsp_score_ff <= div_quotient;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_clarity_score = rsp_score_ff;

   igs_line_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_window (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (in_tag),
      .in_pixel (pixel_thr),
      .in_addr  (col_ff),
      .win_tag  (win_tag),
      .window   (window)
   );

   igs_grad_acc #(
      .SUM_W (SUM_W)
   ) u_grad_acc (
      .clock      (clock),
      .reset      (reset),
      .clear      (cfg_hit),
      .win_tag    (win_tag),
      .window     (window),
      .frame_done (frame_done),
      .frame_sum  (frame_sum)
   );

   igs_divider #(
      .SUM_W     (SUM_W),
      .DEN_W     (DEN_W),
      .FRAC_BITS (SCORE_FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (frame_done),
      .dividend (frame_sum),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule
